// ===== hw/rtl/slu_pkg.sv =====
// ----------------------------------------------------------------------------
// slu_pkg: shared types, constants and table builder
// Register codes, fixed-point widths and the logistic node generator that the
// interpolation table is built from at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package slu_pkg;

  typedef enum logic [1:0] {
    REG_LOW_LEVEL  = 2'd0,
    REG_HIGH_LEVEL = 2'd1,
    REG_MIDPOINT   = 2'd2,
    REG_STEEPNESS  = 2'd3
  } cfg_reg_t;

  localparam int SLOPE_W = 16;  // steepness, Q4.12
  localparam int Z_W     = 17;  // saturated exponent argument, Q5.12
  localparam int FRAC_W  = 16;  // logistic factor, Q0.16
  localparam int REM_W   = 17;  // interpolation weight

  localparam logic [63:0] Q31_ONE = 64'd1 << 31;

  // shift-subtract unsigned divide, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-t) in Q0.31, t in Q31 over [0, 16]
  function automatic logic [63:0] neg_exp_q31(input logic [63:0] t);
    logic [63:0] u;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] d;
    u    = t >> 4;
    sum  = Q31_ONE;
    term = Q31_ONE;
    if (u > Q31_ONE) begin
      u = Q31_ONE;
    end
    for (int i = 1; i <= 24; i++) begin
      if (term != 64'd0) begin
        term = (term * u) >> 31;
        term = udiv64(term, 64'(i));
        sum  = sum + term;
      end
    end
    d = udiv64(64'd1 << 62, sum);
    for (int i = 0; i < 4; i++) begin
      d = (d * d) >> 31;
    end
    return d;
  endfunction

  // table node k of entries, Q0.16
  function automatic logic [FRAC_W-1:0] logit_node(input int k, input int entries);
    logic signed [63:0] z;
    logic [63:0]        t;
    logic [63:0]        e;
    logic [63:0]        den;
    logic [63:0]        f;
    z = $signed(udiv64(64'(k) * (64'd32 << 31), 64'(entries))) - $signed(64'd16 << 31);
    t = (z < 0) ? 64'(-z) : 64'(z);
    if (t > (64'd16 << 31)) begin
      t = 64'd16 << 31;
    end
    e   = neg_exp_q31(t);
    den = Q31_ONE + e;
    f   = udiv64((e << 16) + (den >> 1), den);
    if (z < 0) begin
      f = 64'd65536 - f;
    end
    if (f > 64'd65535) begin
      f = 64'd65535;
    end
    return f[FRAC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/slu_expo.sv =====
// ----------------------------------------------------------------------------
// slu_expo: exponent argument and table index
// Three stages: midpoint difference, slope product, saturation and index split.
// ----------------------------------------------------------------------------
`default_nettype none

module slu_expo #(
  parameter int DATA_WIDTH    = 16,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [DATA_WIDTH-1:0]            sample,
  input  logic signed [DATA_WIDTH-1:0]            midpoint,
  input  logic signed [slu_pkg::SLOPE_W-1:0]      steepness,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0]      idx,
  output logic [slu_pkg::REM_W-1:0]               rem
);
  import slu_pkg::*;

  localparam int NS     = 3;
  localparam int AW     = $clog2(TABLE_ENTRIES + 1);
  localparam int DIFF_W = DATA_WIDTH + 1;
  localparam int PROD_W = DATA_WIDTH + SLOPE_W + 1;
  localparam int SH_W   = PROD_W - 8;
  localparam int PW     = Z_W + AW;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [SH_W-1:0]   sh;
  logic signed [Z_W-1:0]    zsat;
  logic [Z_W-1:0]           zoff;
  logic [PW-1:0]            pos;

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
    end
  end

  // floor to Q.12, clamp to [-16, 16)
  always_comb begin
    sh = prod[PROD_W-1:8];
    if (sh < -SH_W'(65536)) begin
      zsat = -Z_W'(65536);
    end else if (sh > SH_W'(65535)) begin
      zsat = Z_W'(65535);
    end else begin
      zsat = sh[Z_W-1:0];
    end
    zoff = {~zsat[Z_W-1], zsat[Z_W-2:0]};   // z + 16.0
    pos  = PW'(zoff) * PW'(TABLE_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) diff <= DIFF_W'(midpoint) - DIFF_W'(sample);
    if (rdy[1]) prod <= PROD_W'(steepness) * PROD_W'(diff);
    if (rdy[2]) begin
      idx <= pos[PW-1:REM_W];
      rem <= pos[REM_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slu_interp.sv =====
// ----------------------------------------------------------------------------
// slu_interp: logistic table lookup and linear interpolation
// Three stages: registered node read, weighted step product, factor.
// ----------------------------------------------------------------------------
`default_nettype none

module slu_interp #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0]      idx,
  input  logic [slu_pkg::REM_W-1:0]               rem,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [slu_pkg::FRAC_W-1:0]              factor
);
  import slu_pkg::*;

  localparam int NS     = 3;
  localparam int AW     = $clog2(TABLE_ENTRIES + 1);
  localparam int STEP_W = FRAC_W + REM_W + 1;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  logic [FRAC_W-1:0] rom_tbl [TABLE_ENTRIES+1];

  for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_rom
    localparam logic [FRAC_W-1:0] NODE = logit_node(k, TABLE_ENTRIES);
    assign rom_tbl[k] = NODE;
  end

  logic [FRAC_W-1:0]       node_a;
  logic [FRAC_W-1:0]       node_b;
  logic [REM_W-1:0]        rem_r;
  logic [AW-1:0]           idx_up;
  logic signed [FRAC_W:0]  delta;
  logic [FRAC_W-1:0]       delta_mag;
  logic [FRAC_W-1:0]       base;
  logic                    rising;
  logic [STEP_W-1:0]       wprod;
  logic [STEP_W-1:0]       wround;
  logic [FRAC_W:0]         fsum;

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
    end
  end

  always_comb begin
    idx_up    = idx + AW'(1);
    delta     = $signed({1'b0, node_a}) - $signed({1'b0, node_b});
    delta_mag = delta[FRAC_W] ? FRAC_W'(-delta) : delta[FRAC_W-1:0];
    wround    = wprod + STEP_W'(1 << 16);
    if (rising) begin
      fsum = {1'b0, base} + {1'b0, wround[STEP_W-2:REM_W]};
    end else begin
      fsum = {1'b0, base} - {1'b0, wround[STEP_W-2:REM_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      node_a <= rom_tbl[idx];
      node_b <= rom_tbl[idx_up];
      rem_r  <= rem;
    end
    if (rdy[1]) begin
      wprod  <= STEP_W'(delta_mag) * STEP_W'(rem_r);
      base   <= node_a;
      rising <= delta[FRAC_W];
    end
    if (rdy[2]) factor <= fsum[FRAC_W-1:0];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slu_scale.sv =====
// ----------------------------------------------------------------------------
// slu_scale: output level scaling
// Two stages: span times factor, then round, offset and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module slu_scale #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [slu_pkg::FRAC_W-1:0]        factor,
  input  logic signed [DATA_WIDTH-1:0]      low_level,
  input  logic signed [DATA_WIDTH-1:0]      high_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [DATA_WIDTH-1:0]      level
);
  import slu_pkg::*;

  localparam int NS     = 2;
  localparam int SPAN_W = DATA_WIDTH + 1;
  localparam int PROD_W = DATA_WIDTH + FRAC_W + 2;
  localparam int SH_W   = PROD_W - FRAC_W;
  localparam int SUM_W  = SH_W + 1;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  logic signed [SPAN_W-1:0] span;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [SUM_W-1:0]  ysum;
  logic signed [DATA_WIDTH-1:0] ysat;

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
    end
  end

  // saturate when the bits above the result sign disagree with it
  always_comb begin
    span     = SPAN_W'(high_level) - SPAN_W'(low_level);
    prod_rnd = prod + PROD_W'(1 << (FRAC_W - 1));
    ysum     = SUM_W'(low_level) + SUM_W'($signed(prod_rnd[PROD_W-1:FRAC_W]));
    if (ysum[SUM_W-1] && !(&ysum[SUM_W-2:DATA_WIDTH-1])) begin
      ysat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else if (!ysum[SUM_W-1] && (|ysum[SUM_W-2:DATA_WIDTH-1])) begin
      ysat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else begin
      ysat = ysum[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) prod  <= PROD_W'(span) * $signed({2'b00, factor});
    if (rdy[1]) level <= ysat;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scaled_logistic_unit_top.sv =====
// ----------------------------------------------------------------------------
// scaled_logistic_unit_top: generalized logistic sigmoid stream unit
// One sample per cycle while m_axis_tready holds, through the eight-stage
// elastic pipeline (three multiplier stages, one registered table read).
// Synchronous reset clears the pipeline valid bits and loads low 0, high
// 1.0, midpoint 0, steepness 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_logistic_unit_top #(
  parameter int DATA_WIDTH    = 16,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // [DATA_WIDTH-1:0] sample_in, rest zero
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // [DATA_WIDTH-1:0] level_out, rest zero
  output logic [((DATA_WIDTH+7)/8)*8-1:0]            m_axis_tdata,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  slu_pkg::cfg_reg_t                          cfg_index,
  input  logic [(DATA_WIDTH > 16 ? DATA_WIDTH : 16)-1:0] cfg_data
);
  import slu_pkg::*;

  localparam int TW = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int AW = $clog2(TABLE_ENTRIES + 1);

  logic signed [DATA_WIDTH-1:0] low_level;
  logic signed [DATA_WIDTH-1:0] high_level;
  logic signed [DATA_WIDTH-1:0] midpoint;
  logic signed [SLOPE_W-1:0]    steepness;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_level  <= '0;
      high_level <= DATA_WIDTH'(256);
      midpoint   <= '0;
      steepness  <= SLOPE_W'(4096);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOW_LEVEL:  low_level  <= cfg_data[DATA_WIDTH-1:0];
        REG_HIGH_LEVEL: high_level <= cfg_data[DATA_WIDTH-1:0];
        REG_MIDPOINT:   midpoint   <= cfg_data[DATA_WIDTH-1:0];
        REG_STEEPNESS:  steepness  <= cfg_data[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  logic              e_valid, e_ready;
  logic [AW-1:0]     e_idx;
  logic [REM_W-1:0]  e_rem;
  logic              i_valid, i_ready;
  logic [FRAC_W-1:0] i_factor;
  logic signed [DATA_WIDTH-1:0] level;

  slu_expo #(
    .DATA_WIDTH   (DATA_WIDTH),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_expo (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sample   (s_axis_tdata[DATA_WIDTH-1:0]),
    .midpoint (midpoint),
    .steepness(steepness),
    .out_valid(e_valid),
    .out_ready(e_ready),
    .idx      (e_idx),
    .rem      (e_rem)
  );

  slu_interp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_interp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (e_valid),
    .in_ready (e_ready),
    .idx      (e_idx),
    .rem      (e_rem),
    .out_valid(i_valid),
    .out_ready(i_ready),
    .factor   (i_factor)
  );

  slu_scale #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (i_valid),
    .in_ready  (i_ready),
    .factor    (i_factor),
    .low_level (low_level),
    .high_level(high_level),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .level     (level)
  );

  assign m_axis_tdata = TW'($unsigned(level));

  // a drained or draining output never backs up the input
  a_ready_when_sink_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side is ready");

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // nothing comes out right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
